// ----- hw/rtl/hsi2rgbw_pkg.sv -----
// ---------------------------------------------------------------------------
// hsi2rgbw_pkg - shared constants, types and the hue ratio table builder
// Field layout, scaling constants and the cos(h)/cos(60-h) table generator
// used by the HSI to RGBW converter.
// ---------------------------------------------------------------------------
`default_nettype none

package hsi2rgbw_pkg;

  // Default fixed-point formats
  localparam int HUE_FRAC_BITS_DEF   = 4;
  localparam int RATIO_FRAC_BITS_DEF = 14;

  // Field widths
  localparam int HUE_W  = 13;
  localparam int SAT_W  = 11;
  localparam int LVL_W  = 11;
  localparam int CH_W   = 8;

  // Stream packing
  localparam int HUE_LSB    = 0;
  localparam int SAT_LSB    = HUE_LSB + HUE_W;
  localparam int LVL_LSB    = SAT_LSB + SAT_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 4 * CH_W;

  // Scales
  localparam int SECTOR_DEG = 120;
  localparam int HALF_DEG   = 60;
  localparam int FULL_SCALE = 1600;
  localparam int IDX_W      = $clog2(SECTOR_DEG + 1);

  // Level divider: every channel is floor(m / LEVEL_DIV), m clamped to LEVEL_LIMIT
  localparam int LEVEL_DIV    = 3 * FULL_SCALE * FULL_SCALE;
  localparam int LEVEL_LIMIT  = 255 * LEVEL_DIV;
  localparam int LEVEL_RECIP  = 559;   // floor(2^32 / LEVEL_DIV)
  localparam int RECIP_SHIFT  = 32;
  localparam int RECIP_W      = 10;
  localparam int M_W          = 31;
  localparam int WHITE_SCALE  = 3 * 255;

  // Output mode register codes
  localparam logic MODE_RGBW = 1'b0;
  localparam logic MODE_RGB  = 1'b1;

  // Hue sector: which primary carries the ratio term
  typedef enum logic [1:0] {
    SECT_RG = 2'd0,
    SECT_GB = 2'd1,
    SECT_BR = 2'd2
  } sector_t;

  // Q30 one-degree rotation
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint COS_ONE_DEG = 64'sd1073578288;
  localparam longint SIN_ONE_DEG = 64'sd18739379;

  typedef longint ratio_tab_t [0:SECTOR_DEG];

  // shift and subtract quotient, truncated toward zero; dvsr is positive
  function automatic longint div_toward_zero(input longint num, input longint dvsr);
    longint mag;
    longint quo;
    longint part;
    logic   neg;
    neg  = (num < 0);
    mag  = neg ? -num : num;
    quo  = 0;
    part = 0;
    for (int b = 62; b >= 0; b--) begin
      part = (part << 1) | ((mag >> b) & longint'(1));
      if (part >= dvsr) begin
        part = part - dvsr;
        quo  = quo | (longint'(1) << b);
      end
    end
    return neg ? -quo : quo;
  endfunction

  // cos(d)/cos(|60-d|) at whole degrees, frac_bits fraction bits, truncated
  function automatic ratio_tab_t build_ratio_tab(input int frac_bits);
    longint     cosq [0:SECTOR_DEG];
    longint     c;
    longint     s;
    longint     nc;
    longint     ns;
    longint     den;
    int         k;
    ratio_tab_t tab;
    c = Q30_ONE;
    s = 0;
    for (int d = 0; d <= SECTOR_DEG; d++) begin
      cosq[d] = c;
      nc = (c * COS_ONE_DEG - s * SIN_ONE_DEG) / Q30_ONE;
      ns = (s * COS_ONE_DEG + c * SIN_ONE_DEG) / Q30_ONE;
      c  = nc;
      s  = ns;
    end
    for (int d = 0; d <= SECTOR_DEG; d++) begin
      k = HALF_DEG - d;
      if (k < 0) begin
        k = -k;
      end
      den = cosq[k];
      if (den <= 0) begin
        den = 1;
      end
      tab[d] = div_toward_zero(cosq[d] * (longint'(1) << frac_bits), den);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hsi_to_rgbw_converter.sv -----
// ---------------------------------------------------------------------------
// hsi_to_rgbw_converter - HSI to RGBW drive level converter
// Clamps hue, saturation and intensity, interpolates the sector ratio from a
// constant table and scales it to four 8-bit drive levels.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    in_tdata: hue_in, sat_in, level_in
//  out_     out  out_tvalid/out_tready  out_tdata: red, green, blue, white
//  cfg_     in   cfg_valid/cfg_ready    cfg_data: output_mode
//
//  One item per cycle while the output is not held; eight register stages, and
//  a result is offered from the stage 8 register. The longest paths are the level
//  multiply (stage 5) and the reciprocal multiply of the divide by 3*1600^2
//  (stage 7). Reset clears the stage valid bits and the mode register (RGBW).
//  Each stage holds while it is full and the stage after it holds; empty
//  stages keep filling, so input is taken while a result waits at the output.
// ---------------------------------------------------------------------------
`default_nettype none

module hsi_to_rgbw_converter #(
  parameter int HUE_FRAC_BITS   = hsi2rgbw_pkg::HUE_FRAC_BITS_DEF,
  parameter int RATIO_FRAC_BITS = hsi2rgbw_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input items
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [12:0] hue_in, [23:13] sat_in, [34:24] level_in, [39:35] zero
  input  wire logic [hsi2rgbw_pkg::IN_DATA_W-1:0]   in_tdata,
  // result items
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] white_out
  output logic [hsi2rgbw_pkg::OUT_DATA_W-1:0]       out_tdata,
  // configuration
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_data
);

  localparam int NSTG    = 8;
  localparam int CH_W    = hsi2rgbw_pkg::CH_W;
  localparam int SAT_W   = hsi2rgbw_pkg::SAT_W;
  localparam int LVL_W   = hsi2rgbw_pkg::LVL_W;
  localparam int HUE_W   = hsi2rgbw_pkg::HUE_W;
  localparam int IDX_W   = hsi2rgbw_pkg::IDX_W;
  localparam int M_W     = hsi2rgbw_pkg::M_W;
  localparam int FULL    = hsi2rgbw_pkg::FULL_SCALE;
  localparam int SEC_LEN = hsi2rgbw_pkg::SECTOR_DEG << HUE_FRAC_BITS;
  localparam int HUE_MAX = 3 * SEC_LEN;
  localparam int HM_W    = $clog2(HUE_MAX + 1);
  localparam int HX_W    = ((HM_W > HUE_W) ? HM_W : HUE_W) + 1;
  localparam int OFF_W   = $clog2(SEC_LEN + 1);
  localparam int FRAC_W  = (HUE_FRAC_BITS > 0) ? HUE_FRAC_BITS : 1;
  localparam int RW      = RATIO_FRAC_BITS + 4;
  localparam int PI_W    = RW + FRAC_W + 1;
  localparam int OP1_W   = SAT_W + LVL_W;
  localparam int OP2_W   = RATIO_FRAC_BITS + 15;
  localparam int PW      = OP1_W + 1 + OP2_W;
  localparam int NW      = PW + 9;
  localparam int WM_W    = OP1_W + hsi2rgbw_pkg::RECIP_W;
  localparam int RP_W    = M_W + hsi2rgbw_pkg::RECIP_W;
  localparam longint ONE = longint'(1) << RATIO_FRAC_BITS;

  localparam hsi2rgbw_pkg::ratio_tab_t RATIO_TAB =
    hsi2rgbw_pkg::build_ratio_tab(RATIO_FRAC_BITS);

  // -------------------------------------------------------------------------
  // Configuration and flow control
  // -------------------------------------------------------------------------
  logic            mode_r;
  logic [1:NSTG]   v_r;
  logic [1:NSTG]   en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= hsi2rgbw_pkg::MODE_RGBW;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[NSTG] = !v_r[NSTG] || out_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = v_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: clamp, pick sector, split offset into degree and fraction
  // -------------------------------------------------------------------------
  logic [HUE_W-1:0]          in_hue;
  logic [SAT_W-1:0]          in_sat;
  logic [LVL_W-1:0]          in_lvl;
  logic [HX_W-1:0]           hue_x;
  logic [HX_W-1:0]           hue_c;
  logic [HX_W-1:0]           off_x;
  hsi2rgbw_pkg::sector_t     s1_sect_nxt, s1_sect_r;
  logic [IDX_W-1:0]          s1_idx_nxt, s1_idx_r;
  logic [FRAC_W-1:0]         s1_frac_nxt, s1_frac_r;
  logic [SAT_W-1:0]          s1_sat_nxt, s1_sat_r;
  logic [LVL_W-1:0]          s1_lvl_nxt, s1_lvl_r;

  assign in_hue = in_tdata[hsi2rgbw_pkg::HUE_LSB +: HUE_W];
  assign in_sat = in_tdata[hsi2rgbw_pkg::SAT_LSB +: SAT_W];
  assign in_lvl = in_tdata[hsi2rgbw_pkg::LVL_LSB +: LVL_W];

  always_comb begin
    hue_x = HX_W'(in_hue);
    hue_c = (hue_x > HX_W'(HUE_MAX)) ? HX_W'(HUE_MAX) : hue_x;
    priority if (hue_c < HX_W'(SEC_LEN)) begin
      s1_sect_nxt = hsi2rgbw_pkg::SECT_RG;
      off_x       = hue_c;
    end else if (hue_c < HX_W'(2 * SEC_LEN)) begin
      s1_sect_nxt = hsi2rgbw_pkg::SECT_GB;
      off_x       = hue_c - HX_W'(SEC_LEN);
    end else begin
      s1_sect_nxt = hsi2rgbw_pkg::SECT_BR;
      off_x       = hue_c - HX_W'(2 * SEC_LEN);
    end
    s1_idx_nxt  = IDX_W'(OFF_W'(off_x) >> HUE_FRAC_BITS);
    s1_frac_nxt = (HUE_FRAC_BITS == 0) ? '0 : FRAC_W'(off_x);
    s1_sat_nxt  = (in_sat > SAT_W'(FULL)) ? SAT_W'(FULL) : in_sat;
    s1_lvl_nxt  = (in_lvl > LVL_W'(FULL)) ? LVL_W'(FULL) : in_lvl;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sect_r <= s1_sect_nxt;
      s1_idx_r  <= s1_idx_nxt;
      s1_frac_r <= s1_frac_nxt;
      s1_sat_r  <= s1_sat_nxt;
      s1_lvl_r  <= s1_lvl_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: read the ratio at this degree and the next one
  // -------------------------------------------------------------------------
  logic [IDX_W-1:0]          idx_hi;
  logic signed [RW-1:0]      tab_lo;
  logic signed [RW-1:0]      tab_hi;
  logic signed [RW-1:0]      s2_base_nxt, s2_base_r;
  logic signed [RW-1:0]      s2_diff_nxt, s2_diff_r;
  hsi2rgbw_pkg::sector_t     s2_sect_r;
  logic [FRAC_W-1:0]         s2_frac_r;
  logic [SAT_W-1:0]          s2_sat_r;
  logic [LVL_W-1:0]          s2_lvl_r;

  always_comb begin
    // the last degree of a sector has no upper neighbour
    idx_hi = (s1_idx_r == IDX_W'(hsi2rgbw_pkg::SECTOR_DEG)) ? s1_idx_r
                                                            : s1_idx_r + 1'b1;
    tab_lo      = RW'(RATIO_TAB[s1_idx_r]);
    tab_hi      = RW'(RATIO_TAB[idx_hi]);
    s2_base_nxt = tab_lo;
    s2_diff_nxt = tab_hi - tab_lo;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_base_r <= s2_base_nxt;
      s2_diff_r <= s2_diff_nxt;
      s2_sect_r <= s1_sect_r;
      s2_frac_r <= s1_frac_r;
      s2_sat_r  <= s1_sat_r;
      s2_lvl_r  <= s1_lvl_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: interpolate over the fraction of a degree, form S*I
  // -------------------------------------------------------------------------
  logic signed [PI_W-1:0]    ip_prod;
  logic signed [PI_W-1:0]    ip_step;
  logic signed [RW-1:0]      s3_r_nxt, s3_r_r;
  logic [OP1_W-1:0]          s3_sl_nxt, s3_sl_r;
  hsi2rgbw_pkg::sector_t     s3_sect_r;
  logic [SAT_W-1:0]          s3_sat_r;
  logic [LVL_W-1:0]          s3_lvl_r;

  always_comb begin
    ip_prod = PI_W'(s2_diff_r) * PI_W'($signed({1'b0, s2_frac_r}));
    // divide toward zero: bias negative products before the shift
    if (ip_prod < 0) begin
      ip_step = (ip_prod + PI_W'((1 << HUE_FRAC_BITS) - 1)) >>> HUE_FRAC_BITS;
    end else begin
      ip_step = ip_prod >>> HUE_FRAC_BITS;
    end
    s3_r_nxt  = s2_base_r + RW'(ip_step);
    s3_sl_nxt = OP1_W'(s2_sat_r) * OP1_W'(s2_lvl_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_r_r    <= s3_r_nxt;
      s3_sl_r   <= s3_sl_nxt;
      s3_sect_r <= s2_sect_r;
      s3_sat_r  <= s2_sat_r;
      s3_lvl_r  <= s2_lvl_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: mode formulas as one multiplier operand pair per lane
  // lanes: 0 primary, 1 secondary, 2 third
  // -------------------------------------------------------------------------
  logic signed [OP2_W-1:0]   one_x;
  logic signed [OP2_W-1:0]   full_x;
  logic signed [OP2_W-1:0]   r_x;
  logic signed [OP2_W-1:0]   s_x;
  logic signed [OP2_W-1:0]   fa;
  logic signed [OP2_W-1:0]   fb;
  logic [OP1_W-1:0]          s4_op1_nxt, s4_op1_r;
  logic signed [OP2_W-1:0]   s4_op2_nxt [3];
  logic signed [OP2_W-1:0]   s4_op2_r [3];
  logic [OP1_W-1:0]          s4_wn_nxt, s4_wn_r;
  hsi2rgbw_pkg::sector_t     s4_sect_r;

  always_comb begin
    one_x  = OP2_W'(ONE);
    full_x = OP2_W'(longint'(FULL) * ONE);
    r_x    = OP2_W'(s3_r_r);
    s_x    = OP2_W'(s3_sat_r);
    fa     = one_x + r_x;
    fb     = (one_x <<< 1) - r_x;
    if (mode_r == hsi2rgbw_pkg::MODE_RGBW) begin
      s4_op1_nxt    = s3_sl_r;
      s4_op2_nxt[0] = (fa < 0) ? '0 : fa;
      s4_op2_nxt[1] = (fb < 0) ? '0 : fb;
      s4_op2_nxt[2] = '0;
      s4_wn_nxt     = OP1_W'(SAT_W'(FULL) - s3_sat_r) * OP1_W'(s3_lvl_r);
    end else begin
      s4_op1_nxt    = OP1_W'(s3_lvl_r);
      s4_op2_nxt[0] = full_x + s_x * r_x;
      s4_op2_nxt[1] = full_x + s_x * (one_x - r_x);
      s4_op2_nxt[2] = (OP2_W'(FULL) - s_x) * one_x;
      s4_wn_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_op1_r  <= s4_op1_nxt;
      s4_op2_r  <= s4_op2_nxt;
      s4_wn_r   <= s4_wn_nxt;
      s4_sect_r <= s3_sect_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 5: level products
  // -------------------------------------------------------------------------
  logic signed [PW-1:0]      s5_prod_nxt [3];
  logic signed [PW-1:0]      s5_prod_r [3];
  logic [WM_W-1:0]           s5_wm_nxt, s5_wm_r;
  hsi2rgbw_pkg::sector_t     s5_sect_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s5_prod_nxt[k] = PW'($signed({1'b0, s4_op1_r})) * PW'(s4_op2_r[k]);
    end
    // white already on the common divisor scale: 3 * 255 * (1600 - S) * I
    s5_wm_nxt = WM_W'(s4_wn_r) * WM_W'(hsi2rgbw_pkg::WHITE_SCALE);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_prod_r <= s5_prod_nxt;
      s5_wm_r   <= s5_wm_nxt;
      s5_sect_r <= s4_sect_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 6: times 255, drop the ratio fraction, clamp to full scale
  // lanes 0..2 as above, lane 3 white
  // -------------------------------------------------------------------------
  logic signed [NW-1:0]      num;
  logic signed [NW-1:0]      num_sh;
  logic [M_W-1:0]            s6_m_nxt [4];
  logic [M_W-1:0]            s6_m_r [4];
  hsi2rgbw_pkg::sector_t     s6_sect_r;

  always_comb begin
    num    = '0;
    num_sh = '0;
    for (int k = 0; k < 3; k++) begin
      num    = (NW'(s5_prod_r[k]) <<< 8) - NW'(s5_prod_r[k]);
      num_sh = num >>> RATIO_FRAC_BITS;
      if (num <= 0) begin
        s6_m_nxt[k] = '0;
      end else if (num_sh > NW'(hsi2rgbw_pkg::LEVEL_LIMIT)) begin
        s6_m_nxt[k] = M_W'(hsi2rgbw_pkg::LEVEL_LIMIT);
      end else begin
        s6_m_nxt[k] = M_W'(num_sh);
      end
    end
    s6_m_nxt[3] = (s5_wm_r > WM_W'(hsi2rgbw_pkg::LEVEL_LIMIT))
                ? M_W'(hsi2rgbw_pkg::LEVEL_LIMIT) : M_W'(s5_wm_r);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_m_r    <= s6_m_nxt;
      s6_sect_r <= s5_sect_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 7: quotient estimate by reciprocal, low by at most one
  // -------------------------------------------------------------------------
  logic [RP_W-1:0]           rp;
  logic [CH_W-1:0]           s7_q0_nxt [4];
  logic [CH_W-1:0]           s7_q0_r [4];
  logic [M_W-1:0]            s7_m_r [4];
  hsi2rgbw_pkg::sector_t     s7_sect_r;

  always_comb begin
    rp = '0;
    for (int k = 0; k < 4; k++) begin
      rp = RP_W'(s6_m_r[k]) * RP_W'(hsi2rgbw_pkg::LEVEL_RECIP);
      s7_q0_nxt[k] = rp[hsi2rgbw_pkg::RECIP_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_q0_r   <= s7_q0_nxt;
      s7_m_r    <= s6_m_r;
      s7_sect_r <= s6_sect_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 8: correct the quotient, route primaries by sector
  // -------------------------------------------------------------------------
  logic [M_W-1:0]            rem [4];
  logic [CH_W-1:0]           lvl [4];
  logic [CH_W-1:0]           out_red_nxt, out_red_r;
  logic [CH_W-1:0]           out_grn_nxt, out_grn_r;
  logic [CH_W-1:0]           out_blu_nxt, out_blu_r;
  logic [CH_W-1:0]           out_wht_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem[k] = s7_m_r[k] - M_W'(s7_q0_r[k]) * M_W'(hsi2rgbw_pkg::LEVEL_DIV);
      lvl[k] = (rem[k] >= M_W'(hsi2rgbw_pkg::LEVEL_DIV)) ? s7_q0_r[k] + 1'b1
                                                         : s7_q0_r[k];
    end
    unique case (s7_sect_r)
      hsi2rgbw_pkg::SECT_RG: begin
        out_red_nxt = lvl[0];
        out_grn_nxt = lvl[1];
        out_blu_nxt = lvl[2];
      end
      hsi2rgbw_pkg::SECT_GB: begin
        out_red_nxt = lvl[2];
        out_grn_nxt = lvl[0];
        out_blu_nxt = lvl[1];
      end
      hsi2rgbw_pkg::SECT_BR: begin
        out_red_nxt = lvl[1];
        out_grn_nxt = lvl[2];
        out_blu_nxt = lvl[0];
      end
      default: begin
        out_red_nxt = '0;
        out_grn_nxt = '0;
        out_blu_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_red_r <= out_red_nxt;
      out_grn_r <= out_grn_nxt;
      out_blu_r <= out_blu_nxt;
      out_wht_r <= lvl[3];
    end
  end

  assign out_tdata = {out_wht_r, out_blu_r, out_grn_r, out_red_r};

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  a_idx_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (s1_idx_r <= IDX_W'(hsi2rgbw_pkg::SECTOR_DEG)))
    else $error("degree index beyond the sector");

  a_recip_estimate: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] |-> (rem[0] < M_W'(2 * hsi2rgbw_pkg::LEVEL_DIV))
            && (rem[1] < M_W'(2 * hsi2rgbw_pkg::LEVEL_DIV))
            && (rem[2] < M_W'(2 * hsi2rgbw_pkg::LEVEL_DIV))
            && (rem[3] < M_W'(2 * hsi2rgbw_pkg::LEVEL_DIV)))
    else $error("reciprocal quotient estimate off by more than one");

  a_rgbw_no_third: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] && (mode_r == hsi2rgbw_pkg::MODE_RGBW) |-> (s7_m_r[2] == '0))
    else $error("third primary driven in RGBW mode");

  a_rgb_no_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (mode_r == hsi2rgbw_pkg::MODE_RGB) |-> (out_wht_r == '0))
    else $error("white driven in RGB mode");

endmodule

`default_nettype wire

// ----- verif/hsi_to_rgbw_converter_tb.sv -----
// ---------------------------------------------------------------------------
// hsi_to_rgbw_converter_tb - stream test of the HSI to RGBW converter
// Feeds hue, saturation and intensity items through the input stream with
// random gaps on both sides, predicts the red, green, blue and white drive
// levels in both output modes and compares every result item in order.
// ---------------------------------------------------------------------------
module hsi_to_rgbw_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsi2rgbw_pkg::*;

  localparam int     HUE_FB      = HUE_FRAC_BITS_DEF;
  localparam int     RATIO_FB    = RATIO_FRAC_BITS_DEF;
  localparam int     SECTOR_LEN  = SECTOR_DEG << HUE_FB;
  localparam int     HUE_TOP     = 3 * SECTOR_LEN;
  localparam longint RATIO_ONE   = longint'(1) << RATIO_FB;
  localparam longint LVL_DEN     = 3 * longint'(FULL_SCALE) * FULL_SCALE * RATIO_ONE;
  localparam longint WHITE_DEN   = longint'(FULL_SCALE) * FULL_SCALE;
  localparam int     PIPE_DEPTH  = 8;
  localparam int     LONG_HOLD   = 300;
  localparam int     HOLD_AT     = 884;
  localparam int     STALL_LIMIT = 2000;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [SAT_W-1:0] sat;
    logic [HUE_W-1:0] hue;
  } hsi_t;

  typedef struct packed {
    logic [CH_W-1:0] white;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgbw_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [12:0] hue_in, [23:13] sat_in, [34:24] level_in, [39:35] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] white_out
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data   = 1'b0;

  hsi_t   pixel_q[$];
  rgbw_t  want_levels_q[$];
  longint ratio_lut [0:SECTOR_DEG];
  logic   drive_mode   = MODE_RGBW;
  logic   calm         = 1'b0;
  logic   in_fire      = 1'b0;
  int     results_seen = 0;
  int     bad_cnt      = 0;
  int     tx_gap       = 0;
  int     rx_gap       = 0;
  int     hold_left    = 0;
  bit     hold_done    = 1'b0;
  int     idle_cycles  = 0;

  hsi_to_rgbw_converter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cos(d)/cos(|60-d|) at whole degrees, cosines from one-degree rotations in Q30
  function automatic void fill_ratio_lut();
    longint cos_deg [0:SECTOR_DEG];
    longint cr;
    longint sr;
    longint ncr;
    longint dn;
    int     k;
    cr = Q30_ONE;
    sr = 0;
    for (int d = 0; d <= SECTOR_DEG; d++) begin
      cos_deg[d] = cr;
      ncr = (cr * COS_ONE_DEG - sr * SIN_ONE_DEG) / Q30_ONE;
      sr  = (sr * COS_ONE_DEG + cr * SIN_ONE_DEG) / Q30_ONE;
      cr  = ncr;
    end
    for (int d = 0; d <= SECTOR_DEG; d++) begin
      k = (d > HALF_DEG) ? d - HALF_DEG : HALF_DEG - d;
      dn = (cos_deg[k] <= 0) ? 1 : cos_deg[k];
      ratio_lut[d] = (cos_deg[d] * RATIO_ONE) / dn;
    end
  endfunction

  function automatic logic [CH_W-1:0] clip_level(longint num, longint dvsr);
    longint v;
    if (num <= 0) begin
      return '0;
    end
    v = num / dvsr;
    return (v > 255) ? 8'd255 : v[CH_W-1:0];
  endfunction

  function automatic rgbw_t hsi_to_drive(hsi_t px, logic mode);
    longint     h;
    longint     s;
    longint     l;
    longint     off;
    longint     fr;
    longint     r;
    longint     fp;
    longint     fq;
    longint     p;
    longint     q;
    longint     t;
    int         idx;
    sector_t    sect;
    logic [7:0] lead;
    logic [7:0] trail;
    logic [7:0] rest;
    rgbw_t      res;
    h = longint'(px.hue);
    s = longint'(px.sat);
    l = longint'(px.lvl);
    if (h > HUE_TOP) h = longint'(HUE_TOP);
    if (s > FULL_SCALE) s = longint'(FULL_SCALE);
    if (l > FULL_SCALE) l = longint'(FULL_SCALE);
    if (h < SECTOR_LEN) begin
      sect = SECT_RG;
      off  = h;
    end else if (h < 2 * SECTOR_LEN) begin
      sect = SECT_GB;
      off  = h - SECTOR_LEN;
    end else begin
      sect = SECT_BR;
      off  = h - 2 * SECTOR_LEN;
    end
    idx = int'(off >>> HUE_FB);
    if (idx > SECTOR_DEG) idx = SECTOR_DEG;
    fr = off & ((longint'(1) << HUE_FB) - 1);
    r  = ratio_lut[idx];
    // interpolate over the fraction of a degree, truncating toward zero
    if (fr != 0 && idx < SECTOR_DEG) begin
      r += ((ratio_lut[idx + 1] - r) * fr) / (longint'(1) << HUE_FB);
    end
    if (mode == MODE_RGBW) begin
      fp = RATIO_ONE + r;
      fq = 2 * RATIO_ONE - r;
      if (fp < 0) fp = 0;
      if (fq < 0) fq = 0;
      p = 255 * s * l * fp;
      q = 255 * s * l * fq;
      t = 0;
      res.white = clip_level(255 * (FULL_SCALE - s) * l, WHITE_DEN);
    end else begin
      p = 255 * l * (FULL_SCALE * RATIO_ONE + s * r);
      q = 255 * l * (FULL_SCALE * RATIO_ONE + s * (RATIO_ONE - r));
      t = 255 * l * (FULL_SCALE - s) * RATIO_ONE;
      res.white = '0;
    end
    lead  = clip_level(p, LVL_DEN);
    trail = clip_level(q, LVL_DEN);
    rest  = clip_level(t, LVL_DEN);
    case (sect)
      SECT_RG: begin
        res.red = lead;  res.green = trail; res.blue = rest;
      end
      SECT_GB: begin
        res.red = rest;  res.green = lead;  res.blue = trail;
      end
      default: begin
        res.red = trail; res.green = rest;  res.blue = lead;
      end
    endcase
    return res;
  endfunction

  task automatic check_level(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      bad_cnt++;
      if (bad_cnt <= 10) begin
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 results_seen, name, want, got);
      end
    end
  endtask

  task automatic add_pixel(input int h, input int s, input int l);
    hsi_t px;
    px.hue = h[HUE_W-1:0];
    px.sat = s[SAT_W-1:0];
    px.lvl = l[LVL_W-1:0];
    pixel_q.push_back(px);
  endtask

  // hue, saturation and intensity extremes, sector edges and clamping
  task automatic queue_corners();
    add_pixel(0, FULL_SCALE, FULL_SCALE);
    add_pixel(8191, 2047, 2047);
    add_pixel(HUE_TOP, 0, FULL_SCALE);
    add_pixel(SECTOR_LEN, FULL_SCALE, 2047);
    add_pixel(SECTOR_LEN - 1, 800, FULL_SCALE);
    add_pixel(2 * SECTOR_LEN, FULL_SCALE, FULL_SCALE);
    add_pixel(2 * SECTOR_LEN - 1, 2047, 1000);
    add_pixel(HALF_DEG << HUE_FB, FULL_SCALE, FULL_SCALE);
    add_pixel(17, FULL_SCALE - 1, FULL_SCALE + 1);
    add_pixel(HUE_TOP - 1, 1, 1);
    add_pixel(4000, FULL_SCALE, 0);
    add_pixel(HUE_TOP + 1, 1200, 900);
  endtask

  task automatic queue_random(input int n);
    hsi_t px;
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: begin
          px.hue = HUE_W'($urandom);
          px.sat = SAT_W'($urandom);
          px.lvl = LVL_W'($urandom);
        end
        1: begin
          // land on or just below a sector edge; zero minus one wraps to a clamped hue
          px.hue = 13'(SECTOR_LEN * $urandom_range(0, 3) - $urandom_range(0, 1));
          px.sat = $urandom_range(0, 1) ? 11'(FULL_SCALE) : 11'($urandom_range(0, 2));
          px.lvl = $urandom_range(0, 1) ? 11'(FULL_SCALE) : 11'($urandom_range(0, 2047));
        end
        default: begin
          px.hue = HUE_W'($urandom_range(0, HUE_TOP));
          px.sat = SAT_W'($urandom_range(0, FULL_SCALE));
          px.lvl = LVL_W'($urandom_range(0, FULL_SCALE));
        end
      endcase
      pixel_q.push_back(px);
    end
  endtask

  // wait until every item has gone through and its result has arrived
  task automatic drain();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_tvalid || want_levels_q.size() != 0);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    drive_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver: hold an offered item until taken, then advance
  always @(negedge clk) begin
    if (!in_tvalid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        tx_gap    = $urandom_range(1, 12) - 1;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_tdata  <= {{(IN_DATA_W - $bits(hsi_t)){1'b0}}, pixel_q.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the pipeline up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on each taken item, compare each result item
  always @(posedge clk) begin
    rgbw_t seen;
    rgbw_t want;
    in_fire <= in_tvalid && in_tready;
    if (out_tvalid && out_tready) begin
      seen = out_tdata;
      if (want_levels_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) begin
          $display("result item with nothing expected: %h", out_tdata);
        end
      end else begin
        want = want_levels_q.pop_front();
        check_level("red", want.red, seen.red);
        check_level("green", want.green, seen.green);
        check_level("blue", want.blue, seen.blue);
        check_level("white", want.white, seen.white);
      end
      results_seen++;
    end
    if (in_tvalid && in_tready) begin
      want_levels_q.push_back(hsi_to_drive(hsi_t'(in_tdata[$bits(hsi_t)-1:0]), drive_mode));
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    fill_ratio_lut();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_corners();
    drain();
    write_mode(MODE_RGB);
    queue_corners();
    drain();

    write_mode(MODE_RGBW);
    queue_random(400);
    drain();
    write_mode(MODE_RGB);
    queue_random(400);
    drain();
    write_mode(MODE_RGBW);
    queue_random(250);
    drain();

    // closing stretch at full rate on both sides
    calm = 1'b1;
    write_mode(MODE_RGB);
    queue_random(200);
    drain();
    repeat (PIPE_DEPTH) @(posedge clk);

    if (bad_cnt == 0 && want_levels_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
